// ----- sv/m4i_pkg.sv -----
package m4i_pkg;

  typedef enum logic [2:0] {
    S_LOAD,
    S_COF_GO,
    S_COF_WAIT,
    S_DET_GO,
    S_DET_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_FETCH,
    L_MUL,
    L_ACC,
    L_DNUM,
    L_DCHK,
    L_DIV
  } lane_state_t;

  typedef enum logic [1:0] {
    X_ELEM,
    X_MINOR,
    X_COF0
  } xsrc_t;

  typedef enum logic [1:0] {
    D_MINOR,
    D_COF,
    D_PART
  } dst_t;

  typedef struct packed {
    xsrc_t      xsrc;
    logic [1:0] xr;
    logic [1:0] xc;
    logic [1:0] yr;
    logic [1:0] yc;
    dst_t       dst;
    logic       sub;
    logic       clr;
    logic       full;
  } op_t;

  typedef struct packed {
    logic       start_cof;
    logic       start_div;
    logic [1:0] col;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic ovf;
    logic neg;
  } lane_stat_t;

  localparam logic [3:0] STEP_COF_END = 4'd8;
  localparam logic [3:0] STEP_DET     = 4'd9;

  localparam int TU_SINGULAR = 0;
  localparam int TU_SAT      = 1;

  // index of the s-th kept row/column when k is struck out
  function automatic logic [1:0] m4i_skip(input logic [1:0] s, input logic [1:0] k);
    m4i_skip = (s >= k) ? s + 2'd1 : s;
  endfunction

  // 3x3 determinant by expansion along its first row, then the det partial
  function automatic op_t m4i_op(input logic [3:0] step);
    op_t op;
    op = '0;
    unique case (step)
      4'd0: op = '{X_ELEM,  2'd1, 2'd1, 2'd2, 2'd2, D_MINOR, 1'b0, 1'b1, 1'b0};
      4'd1: op = '{X_ELEM,  2'd1, 2'd2, 2'd2, 2'd1, D_MINOR, 1'b1, 1'b0, 1'b0};
      4'd2: op = '{X_MINOR, 2'd0, 2'd0, 2'd0, 2'd0, D_COF,   1'b0, 1'b1, 1'b0};
      4'd3: op = '{X_ELEM,  2'd1, 2'd0, 2'd2, 2'd2, D_MINOR, 1'b0, 1'b1, 1'b0};
      4'd4: op = '{X_ELEM,  2'd1, 2'd2, 2'd2, 2'd0, D_MINOR, 1'b1, 1'b0, 1'b0};
      4'd5: op = '{X_MINOR, 2'd0, 2'd0, 2'd0, 2'd1, D_COF,   1'b1, 1'b0, 1'b0};
      4'd6: op = '{X_ELEM,  2'd1, 2'd0, 2'd2, 2'd1, D_MINOR, 1'b0, 1'b1, 1'b0};
      4'd7: op = '{X_ELEM,  2'd1, 2'd1, 2'd2, 2'd0, D_MINOR, 1'b1, 1'b0, 1'b0};
      4'd8: op = '{X_MINOR, 2'd0, 2'd0, 2'd0, 2'd2, D_COF,   1'b0, 1'b0, 1'b0};
      4'd9: op = '{X_COF0,  2'd0, 2'd0, 2'd0, 2'd0, D_PART,  1'b0, 1'b1, 1'b1};
      default: op = '0;
    endcase
    return op;
  endfunction

endpackage

// ----- sv/mat4_inverse.sv -----
// 4x4 matrix inverse by adjugate. A matrix enters as four requests, one row
// each (col0 in the low bits of in_tdata), accepted while in_tready is high.
// After the fourth row, four lanes (one per cofactor row) each compute their
// four 3x3 cofactors with a digit-serial multiply-accumulate, 8 bits of
// multiplier per cycle, each product in a fetch, multiply and accumulate step,
// 37 products per lane; the merge stage sums the determinant in registered
// adder stages. Each inverse row is then found by restoring division in all
// lanes at once and handed to the output register; a singular matrix skips
// the division. Results are rounded to nearest, saturated, and carry singular
// (tuser bit 0), saturated (tuser bit 1) and tlast on the fourth row. A new
// matrix is taken while the last result row still waits.
module mat4_inverse #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // col0, col1, col2, col3, zero fill
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // inv_col0, inv_col1, inv_col2, inv_col3, zero fill
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic out_tlast,
  // singular, saturated
  output logic [1:0] out_tuser
);
  import m4i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int DETW = 4 * DW + 2;
  localparam int TDW  = ((4 * DW + 7) / 8) * 8;

  top_state_t state_r, state_nxt;

  logic [1:0]     rows_loaded_r;
  logic [1:0]     row_r;
  logic           in_acc;
  logic           out_free;
  logic           load;
  logic           m_go;
  logic           m_busy;
  logic           det_zero;
  logic [DETW-1:0] dmag, den;
  logic [4*DW-1:0] row_data;
  logic           row_sat;
  lane_ctl_t      ctl;
  lane_stat_t     stat [4];
  logic signed [DETW-1:0] part [4];
  logic [DW-1:0]  quo [4];
  logic           lanes_busy;

  logic           out_tvalid_r;
  logic [TDW-1:0] out_tdata_r;
  logic           out_tlast_r;
  logic [1:0]     out_tuser_r;

  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign lanes_busy = stat[0].busy | stat[1].busy | stat[2].busy | stat[3].busy;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    m4i_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .lane_id (2'(g)),
      .ctl     (ctl),
      .wr_en   (in_acc),
      .wr_row  (rows_loaded_r),
      .wr_data (in_tdata[4*DW-1:0]),
      .dmag    (dmag),
      .den     (den),
      .stat    (stat[g]),
      .part    (part[g]),
      .quo     (quo[g])
    );
  end

  m4i_merge #(.DATA_WIDTH(DW)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (m_go),
    .part     (part),
    .quo      (quo),
    .stat     (stat),
    .busy     (m_busy),
    .det_zero (det_zero),
    .dmag     (dmag),
    .den      (den),
    .row_data (row_data),
    .row_sat  (row_sat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc && rows_loaded_r == 2'd3) begin
          state_nxt = S_COF_GO;
        end
      end
      S_COF_GO: state_nxt = S_COF_WAIT;
      S_COF_WAIT: begin
        if (!lanes_busy) begin
          state_nxt = S_DET_GO;
        end
      end
      S_DET_GO: state_nxt = S_DET_WAIT;
      S_DET_WAIT: begin
        if (!m_busy) begin
          state_nxt = det_zero ? S_EMIT : S_DIV_GO;
        end
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!lanes_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (row_r == 2'd3) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = det_zero ? S_EMIT : S_DIV_GO;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == S_LOAD);
    ctl.start_cof = (state_r == S_COF_GO);
    ctl.start_div = (state_r == S_DIV_GO);
    ctl.col       = row_r;
    m_go          = (state_r == S_DET_GO);
    load          = (state_r == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      rows_loaded_r <= 2'd0;
      row_r         <= 2'd0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        rows_loaded_r <= rows_loaded_r + 2'd1;
      end
      if (state_r == S_COF_GO) begin
        row_r <= 2'd0;
      end else if (load) begin
        row_r <= row_r + 2'd1;
      end
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tlast_r <= (row_r == 2'd3);
      if (det_zero) begin
        out_tdata_r <= '0;
        out_tuser_r <= 2'b01;
      end else begin
        out_tdata_r <= TDW'(row_data);
        out_tuser_r <= {row_sat, 1'b0};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !lanes_busy && !m_busy)
    else $error("lanes active while taking rows");

  a_merge_alone: assert property (@(posedge clk) disable iff (!rst_n)
    m_busy |-> !lanes_busy)
    else $error("determinant merge overlaps lane work");

  a_singular_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TU_SINGULAR] |-> out_tdata == '0 && !out_tuser[TU_SAT])
    else $error("singular row carries data or saturation");

endmodule

// ----- sv/m4i_ram.sv -----
module m4i_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/m4i_lane.sv -----
module m4i_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  lane_id,
  input  m4i_pkg::lane_ctl_t          ctl,
  input  logic                        wr_en,
  input  logic [1:0]                  wr_row,
  input  logic [4*DATA_WIDTH-1:0]     wr_data,
  input  logic [4*DATA_WIDTH+1:0]     dmag,
  input  logic [4*DATA_WIDTH+1:0]     den,
  output m4i_pkg::lane_stat_t         stat,
  output logic signed [4*DATA_WIDTH+1:0] part,
  output logic [DATA_WIDTH-1:0]       quo
);
  import m4i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int CW   = 3 * DW + 2;
  localparam int DETW = 4 * DW + 2;
  localparam int DIG  = (DW + 7) / 8;
  localparam int YW   = DIG * 8;
  localparam int DIGW = $clog2(DIG);
  localparam int NUMW = 5 * DW + 2 * FRAC_BITS + 4;
  localparam int HW   = NUMW - DW;
  localparam int CNTW = $clog2(DW);
  localparam int SH   = 2 * FRAC_BITS + 1;

  lane_state_t state_r, state_nxt;

  logic [1:0]             j_r;
  logic [3:0]             step_r;
  logic [DIGW-1:0]        dig_r;
  logic signed [DETW-1:0] prod_r;
  logic signed [CW-1:0]   minor_r;
  logic signed [CW-1:0]   cacc_r;
  logic signed [CW-1:0]   cof_r [4];
  logic signed [DETW-1:0] part_r;
  logic [1:0]             col_r;
  logic [NUMW-1:0]        num_r;
  logic [DETW-1:0]        rem_r;
  logic [DW-1:0]          nlo_r;
  logic [DW-1:0]          q_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   ovf_r;
  logic                   neg_r;

  op_t                    op;
  logic [1:0]             xrow, xcol, yrow, ycol;
  logic [4*DW-1:0]        row_a, row_b;
  logic signed [DW-1:0]   xe, ye;
  logic signed [YW-1:0]   y_ext;
  logic signed [CW-1:0]   x_op;
  logic [7:0]             digit;
  logic signed [8:0]      dig9;
  logic signed [CW+8:0]   mulp;
  logic signed [DETW-1:0] prod_nxt;
  logic                   sub_eff;
  logic signed [CW-1:0]   pc, minor_base, cacc_base, minor_calc, cacc_calc;
  logic signed [CW-1:0]   cof_sel;
  logic [CW-1:0]          mag;
  logic [NUMW-1:0]        num_nxt;
  logic [DETW:0]          rem_sh;
  logic                   ge;

  m4i_ram #(.WIDTH(4 * DW), .DEPTH(4)) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_row),
    .wdata   (wr_data),
    .raddr_a (xrow),
    .rdata_a (row_a),
    .raddr_b (yrow),
    .rdata_b (row_b)
  );

  always_comb begin
    op   = m4i_op(step_r);
    xrow = m4i_skip(op.xr, lane_id);
    xcol = m4i_skip(op.xc, j_r);
    yrow = op.full ? lane_id : m4i_skip(op.yr, lane_id);
    ycol = op.full ? 2'd0 : m4i_skip(op.yc, j_r);
  end

  always_comb begin
    xe    = row_a[DW*xcol +: DW];
    ye    = row_b[DW*ycol +: DW];
    y_ext = YW'(ye);
    unique case (op.xsrc)
      X_ELEM:  x_op = CW'(xe);
      X_MINOR: x_op = minor_r;
      X_COF0:  x_op = cof_r[0];
      default: x_op = '0;
    endcase
    digit    = y_ext[8*dig_r +: 8];
    dig9     = (dig_r == DIGW'(DIG - 1)) ? {digit[7], digit} : {1'b0, digit};
    mulp     = x_op * dig9;
    prod_nxt = ((dig_r == DIGW'(DIG - 1)) ? DETW'(0) : (prod_r <<< 8)) + DETW'(mulp);
  end

  always_comb begin
    pc         = prod_r[CW-1:0];
    sub_eff    = op.sub ^ ((op.dst == D_COF) && (lane_id[0] ^ j_r[0]));
    minor_base = op.clr ? CW'(0) : minor_r;
    cacc_base  = op.clr ? CW'(0) : cacc_r;
    minor_calc = sub_eff ? minor_base - pc : minor_base + pc;
    cacc_calc  = sub_eff ? cacc_base - pc : cacc_base + pc;
  end

  always_comb begin
    cof_sel = cof_r[col_r];
    mag     = cof_sel[CW-1] ? CW'(-cof_sel) : cof_sel;
    num_nxt = (NUMW'(mag) << SH) + NUMW'(dmag);
    rem_sh  = {rem_r, nlo_r[DW-1]};
    ge      = rem_sh >= {1'b0, den};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: begin
        if (ctl.start_cof) begin
          state_nxt = L_FETCH;
        end else if (ctl.start_div) begin
          state_nxt = L_DNUM;
        end
      end
      L_FETCH: state_nxt = L_MUL;
      L_MUL: begin
        if (dig_r == '0) begin
          state_nxt = L_ACC;
        end
      end
      L_ACC:  state_nxt = (step_r == STEP_DET) ? L_IDLE : L_FETCH;
      L_DNUM: state_nxt = L_DCHK;
      L_DCHK: state_nxt = (num_r[NUMW-1:DW] >= HW'(den)) ? L_IDLE : L_DIV;
      L_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      L_IDLE: begin
        j_r    <= 2'd0;
        step_r <= 4'd0;
        col_r  <= ctl.col;
      end
      L_FETCH: dig_r <= DIGW'(DIG - 1);
      L_MUL: begin
        prod_r <= prod_nxt;
        dig_r  <= dig_r - DIGW'(1);
      end
      L_ACC: begin
        unique case (op.dst)
          D_MINOR: minor_r <= minor_calc;
          D_COF:   cacc_r  <= cacc_calc;
          D_PART:  part_r  <= prod_r;
          default: part_r  <= prod_r;
        endcase
        if (step_r == STEP_COF_END) begin
          cof_r[j_r] <= cacc_calc;
          if (j_r == 2'd3) begin
            step_r <= STEP_DET;
          end else begin
            j_r    <= j_r + 2'd1;
            step_r <= 4'd0;
          end
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
      L_DNUM: begin
        num_r <= num_nxt;
        neg_r <= cof_sel[CW-1];
      end
      L_DCHK: begin
        ovf_r <= num_r[NUMW-1:DW] >= HW'(den);
        rem_r <= num_r[DW +: DETW];
        nlo_r <= num_r[DW-1:0];
        cnt_r <= CNTW'(DW - 1);
      end
      L_DIV: begin
        rem_r <= ge ? DETW'(rem_sh - {1'b0, den}) : rem_sh[DETW-1:0];
        q_r   <= {q_r[DW-2:0], ge};
        nlo_r <= nlo_r << 1;
        cnt_r <= cnt_r - CNTW'(1);
      end
      default: ;
    endcase
  end

  assign stat.busy = (state_r != L_IDLE);
  assign stat.ovf  = ovf_r;
  assign stat.neg  = neg_r;
  assign part      = part_r;
  assign quo       = q_r;

endmodule

// ----- sv/m4i_merge.sv -----
module m4i_merge #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic signed [4*DATA_WIDTH+1:0] part [4],
  input  logic [DATA_WIDTH-1:0]          quo [4],
  input  m4i_pkg::lane_stat_t            stat [4],
  output logic                           busy,
  output logic                           det_zero,
  output logic [4*DATA_WIDTH+1:0]        dmag,
  output logic [4*DATA_WIDTH+1:0]        den,
  output logic [4*DATA_WIDTH-1:0]        row_data,
  output logic                           row_sat
);
  import m4i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int DETW = 4 * DW + 2;
  localparam logic [DW-1:0] LIM = {1'b1, {(DW-1){1'b0}}};

  logic                   v1_r, v2_r;
  logic signed [DETW-1:0] s01_r, s23_r, det_r;
  logic [DETW-1:0]        dmag_r;
  logic                   zero_r, neg_r;
  logic                   n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s01_r <= part[0] + part[1];
      s23_r <= part[2] + part[3];
    end
    if (v1_r) begin
      det_r <= s01_r + s23_r;
    end
    if (v2_r) begin
      dmag_r <= det_r[DETW-1] ? DETW'(-det_r) : det_r;
      zero_r <= (det_r == '0);
      neg_r  <= det_r[DETW-1];
    end
  end

  assign busy     = v1_r | v2_r;
  assign det_zero = zero_r;
  assign dmag     = dmag_r;
  assign den      = dmag_r << 1;

  always_comb begin
    row_sat = 1'b0;
    n       = 1'b0;
    for (int c = 0; c < 4; c++) begin
      n = stat[c].neg ^ neg_r;
      if (n) begin
        if (stat[c].ovf || quo[c] > LIM) begin
          row_data[DW*c +: DW] = LIM;
          row_sat = 1'b1;
        end else begin
          row_data[DW*c +: DW] = DW'(-quo[c]);
        end
      end else begin
        if (stat[c].ovf || quo[c] >= LIM) begin
          row_data[DW*c +: DW] = ~LIM;
          row_sat = 1'b1;
        end else begin
          row_data[DW*c +: DW] = quo[c];
        end
      end
    end
  end

endmodule
